>>> rtl/two_channel_note_sequencer_top_defines.svh
// two_channel_note_sequencer_top_defines.svh
// assertion macros shared by the checker; no dependencies
`ifndef TWO_CHANNEL_NOTE_SEQUENCER_TOP_DEFINES_SVH
`define TWO_CHANNEL_NOTE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TCNS_ASSERT_IMP(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("tcns check failed");

// next-cycle implication, disabled in reset
`define TCNS_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("tcns check failed");

`endif

>>> rtl/tcns_pkg.sv
// tcns_pkg.sv
// payload types, codes and the tone table of the note sequencer; no dependencies
package tcns_pkg;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  addr;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
        logic        player_busy;
    } item_t;

    typedef struct packed {
        logic        tone_cmd;
        logic [12:0] freq_hz;
        logic [30:0] duration_ms;
        logic        from_channel;
    } result_t;

    localparam logic [2:0] FUNC_POLL   = 3'd0;
    localparam logic [2:0] FUNC_WRITE  = 3'd1;
    localparam logic [2:0] FUNC_EFFECT = 3'd2;
    localparam logic [2:0] FUNC_MUSIC  = 3'd3;
    localparam logic [2:0] FUNC_STOP   = 3'd4;

    localparam logic [1:0] REG_END_MARKER   = 2'd0;
    localparam logic [1:0] REG_SOUND_ENABLE = 2'd1;
    localparam logic [1:0] REG_MUSIC_ENABLE = 2'd2;

    localparam logic CMD_PLAY    = 1'b0;
    localparam logic CMD_SILENCE = 1'b1;
    localparam logic CH_EFFECT   = 1'b0;
    localparam logic CH_MUSIC    = 1'b1;

    localparam int          NOTE_COUNT   = 12;
    localparam logic [4:0]  MAX_EXPONENT = 5'd30;
    localparam logic [3:0]  TOP_OCTAVE   = 4'd11;

    // base tone table, scaled by 2^11
    function automatic logic [15:0] tone_base(input logic [3:0] note);
        logic [15:0] v;
        case (note)
            4'd0:    v = 16'd33488;
            4'd1:    v = 16'd35479;
            4'd2:    v = 16'd37589;
            4'd3:    v = 16'd39824;
            4'd4:    v = 16'd42192;
            4'd5:    v = 16'd44701;
            4'd6:    v = 16'd47359;
            4'd7:    v = 16'd50175;
            4'd8:    v = 16'd53159;
            4'd9:    v = 16'd56320;
            4'd10:   v = 16'd59669;
            4'd11:   v = 16'd63217;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/tcns_ram.sv
// tcns_ram.sv
// generic single-port ram with registered read; no dependencies
module tcns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, and registered read of the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/tcns_decode.sv
// tcns_decode.sv
// note byte to frequency and duration; uses tcns_pkg
module tcns_decode (
    input  logic [7:0]  note_byte,
    input  logic [2:0]  octave,
    input  logic [4:0]  exponent,
    output logic [12:0] freq_hz,
    output logic [30:0] duration_ms
);
    import tcns_pkg::*;

    logic [3:0]  note;
    logic [3:0]  oct;
    logic [1:0]  dshift;
    logic [4:0]  sh;
    logic [30:0] base;
    logic [15:0] tone;

    // duration: 2^(exponent-shift), saturating, plus half when dotted; frequency from the tone table by octave
    always_comb
    begin
        note   = note_byte[7:4];
        oct    = {3'b000, note_byte[3]} + {1'b0, octave};
        dshift = note_byte[2:1];
        sh     = (exponent >= {3'b000, dshift}) ? exponent - {3'b000, dshift} : 5'd0;
        if (sh > MAX_EXPONENT)
        begin
            sh = MAX_EXPONENT;
        end
        base        = 31'd1 << sh;
        duration_ms = note_byte[0] ? base + (base >> 1) : base;
        tone        = tone_base(note);
        if (note < 4'(NOTE_COUNT) && oct <= TOP_OCTAVE)
        begin
            freq_hz = 13'(tone >> (TOP_OCTAVE - oct));
        end
        else
        begin
            freq_hz = 13'd0;
        end
    end

endmodule

>>> rtl/tcns_rem.sv
// tcns_rem.sv
// restoring remainder unit, one dividend bit per cycle; no dependencies
module tcns_rem #(
    parameter int LAP_W = 42
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [32:0]      dividend,
    input  logic [LAP_W-1:0] divisor,
    output logic             done,
    output logic [32:0]      remainder
);

    logic             running_reg;
    logic [5:0]       cnt_reg;
    logic [32:0]      num_reg;
    logic [LAP_W-1:0] div_reg;
    logic [LAP_W-1:0] rem_reg;
    logic [LAP_W:0]   trial;

    assign trial     = {rem_reg, num_reg[32]};
    assign done      = running_reg && (cnt_reg == 6'd0);
    assign remainder = rem_reg[32:0];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cnt_reg     <= 6'd0;
        end
        else if (start)
        begin
            running_reg <= 1'b1;
            cnt_reg     <= 6'd33;
        end
        else if (done)
        begin
            running_reg <= 1'b0;
        end
        else if (running_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
        end
    end

    // shift-subtract datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (running_reg && cnt_reg != 6'd0)
        begin
            num_reg <= {num_reg[31:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                rem_reg <= LAP_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_reg <= trial[LAP_W-1:0];
            end
        end
    end

endmodule

>>> rtl/two_channel_note_sequencer_top.sv
// channel   dir  handshake                  payload
// item      in   item_valid / item_ready    tcns_pkg::item_t
// result    out  result_valid / result_ready tcns_pkg::result_t
// config    in   apb psel/penable/pwrite    32-bit registers at 0, 4, 8
//
// store writes, stops and unknown codes end at accept; starts pass a header state.
// ticks go S_POLL, then S_EFF, S_MTRY, S_MUS as needed: sound off ends in S_POLL,
// busy ends in S_MTRY; fast-forward walks S_FF_CHK and S_FF_RD per stored note
// walked via the store read port, and S_FF_GO, S_FF_MOD once a store lap is walked.
// item_ready stays low while an item is at work or a result waits.
// rst_n is asynchronous; the store holds no reset and must be written before use.
// depends on tcns_pkg, tcns_ram, tcns_decode, tcns_rem
module two_channel_note_sequencer_top #(
    parameter int STORE_BYTES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  tcns_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output tcns_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tcns_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int STEP_W = ADDR_W + 1;
    localparam int LAP_W  = ADDR_W + 32;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HDR_E  = 4'd1;
    localparam logic [3:0] S_HDR_M  = 4'd2;
    localparam logic [3:0] S_POLL   = 4'd3;
    localparam logic [3:0] S_EFF    = 4'd4;
    localparam logic [3:0] S_MTRY   = 4'd5;
    localparam logic [3:0] S_MUS    = 4'd6;
    localparam logic [3:0] S_FF_CHK = 4'd7;
    localparam logic [3:0] S_FF_RD  = 4'd8;
    localparam logic [3:0] S_FF_GO  = 4'd9;
    localparam logic [3:0] S_FF_MOD = 4'd10;

    logic [3:0]        state_reg;
    item_t             cur_reg;
    logic [7:0]        end_marker_reg;
    logic              sound_en_reg;
    logic              music_en_reg;
    logic              eff_active_reg;
    logic [ADDR_W-1:0] eff_pos_reg;
    logic [2:0]        eff_oct_reg;
    logic [4:0]        eff_exp_reg;
    logic              mus_active_reg;
    logic [ADDR_W-1:0] mus_pos_reg;
    logic [ADDR_W-1:0] mus_base_reg;
    logic [2:0]        mus_oct_reg;
    logic [4:0]        mus_exp_reg;
    logic              mus_loop_reg;
    logic [31:0]       last_start_reg;
    logic [12:0]       last_freq_reg;
    logic [30:0]       last_len_reg;
    logic              catch_up_reg;
    logic [32:0]       ff_reg;
    logic [12:0]       f_reg;
    logic [30:0]       d_reg;
    logic [LAP_W-1:0]  lap_reg;
    logic [STEP_W-1:0] steps_reg;
    logic              skipped_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              accept;
    logic              cfg_we;
    logic [16:0]       addr_ext;
    logic [ADDR_W-1:0] item_idx;
    logic [16:0]       cur_addr_ext;
    logic [ADDR_W-1:0] cur_idx;
    logic [ADDR_W-1:0] ram_addr;
    logic              ram_we;
    logic [7:0]        rdata;
    logic [2:0]        dec_oct;
    logic [4:0]        dec_exp;
    logic [12:0]       dec_freq;
    logic [30:0]       dec_dur;
    logic [2:0]        hdr_oct;
    logic [4:0]        hdr_exp;
    logic              is_end;
    logic [LAP_W-1:0]  lap_sum;
    logic              rem_start;
    logic              rem_done;
    logic [32:0]       rem_val;

    assign accept       = item_valid && item_ready;
    assign item_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pready       = 1'b1;
    assign cfg_we       = psel && penable && pwrite;
    assign addr_ext     = {7'b0, item.addr};
    assign item_idx     = addr_ext[ADDR_W-1:0];
    assign cur_addr_ext = {7'b0, cur_reg.addr};
    assign cur_idx      = cur_addr_ext[ADDR_W-1:0];
    assign is_end       = (rdata == end_marker_reg);
    assign lap_sum      = lap_reg + LAP_W'(dec_dur);
    assign rem_start    = (state_reg == S_FF_GO);

    // header fields with the exponent clamp
    always_comb
    begin
        hdr_oct = rdata[7:5];
        hdr_exp = (rdata[4:0] > MAX_EXPONENT) ? MAX_EXPONENT : rdata[4:0];
    end

    // store address and write enable select, and decoder field select
    always_comb
    begin
        ram_we = accept && (item.func == FUNC_WRITE);
        unique case (state_reg)
            S_IDLE:  ram_addr = item_idx;
            S_POLL:  ram_addr = eff_pos_reg;
            default: ram_addr = mus_pos_reg;
        endcase
        dec_oct = (state_reg == S_EFF) ? eff_oct_reg : mus_oct_reg;
        dec_exp = (state_reg == S_EFF) ? eff_exp_reg : mus_exp_reg;
    end

    tcns_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.data_byte),
        .rdata (rdata)
    );

    tcns_decode u_decode (
        .note_byte   (rdata),
        .octave      (dec_oct),
        .exponent    (dec_exp),
        .freq_hz     (dec_freq),
        .duration_ms (dec_dur)
    );

    tcns_rem #(
        .LAP_W (LAP_W)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (ff_reg),
        .divisor   (lap_reg),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            REG_END_MARKER:   prdata = {24'd0, end_marker_reg};
            REG_SOUND_ENABLE: prdata = {31'd0, sound_en_reg};
            REG_MUSIC_ENABLE: prdata = {31'd0, music_en_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_marker_reg <= 8'hFF;
            sound_en_reg   <= 1'b1;
            music_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_END_MARKER:   end_marker_reg <= pwdata[7:0];
                REG_SOUND_ENABLE: sound_en_reg   <= pwdata[0];
                REG_MUSIC_ENABLE: music_en_reg   <= pwdata[0];
                default:          ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            eff_active_reg <= 1'b0;
            eff_pos_reg    <= '0;
            eff_oct_reg    <= 3'd0;
            eff_exp_reg    <= 5'd0;
            mus_active_reg <= 1'b0;
            mus_pos_reg    <= '0;
            mus_base_reg   <= '0;
            mus_oct_reg    <= 3'd0;
            mus_exp_reg    <= 5'd0;
            mus_loop_reg   <= 1'b0;
            last_start_reg <= 32'd0;
            last_freq_reg  <= 13'd0;
            last_len_reg   <= 31'd0;
            catch_up_reg   <= 1'b0;
            ff_reg         <= '0;
            f_reg          <= '0;
            d_reg          <= '0;
            lap_reg        <= '0;
            steps_reg      <= '0;
            skipped_reg    <= 1'b0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cur_reg <= item;
                        case (item.func)
                            FUNC_EFFECT: state_reg <= S_HDR_E;
                            FUNC_MUSIC:  state_reg <= S_HDR_M;
                            FUNC_POLL:   state_reg <= S_POLL;
                            FUNC_STOP:   mus_loop_reg <= 1'b0;
                            default:     ;
                        endcase
                    end
                end
                S_HDR_E:
                begin
                    eff_active_reg <= 1'b1;
                    eff_oct_reg    <= hdr_oct;
                    eff_exp_reg    <= hdr_exp;
                    eff_pos_reg    <= cur_idx + 1'b1;
                    catch_up_reg   <= 1'b1;
                    out_reg        <= '{CMD_SILENCE, 13'd0, 31'd0, CH_EFFECT};
                    out_valid_reg  <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                S_HDR_M:
                begin
                    mus_active_reg <= 1'b1;
                    mus_base_reg   <= cur_idx;
                    mus_oct_reg    <= hdr_oct;
                    mus_exp_reg    <= hdr_exp;
                    mus_pos_reg    <= cur_idx + 1'b1;
                    mus_loop_reg   <= 1'b1;
                    last_start_reg <= cur_reg.now_ms;
                    catch_up_reg   <= 1'b0;
                    state_reg      <= S_IDLE;
                end
                S_POLL:
                begin
                    if (!sound_en_reg)
                    begin
                        eff_active_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                    else if (!cur_reg.player_busy && eff_active_reg)
                    begin
                        eff_pos_reg <= eff_pos_reg + 1'b1;
                        state_reg   <= S_EFF;
                    end
                    else
                    begin
                        state_reg <= S_MTRY;
                    end
                end
                S_EFF:
                begin
                    if (is_end)
                    begin
                        eff_active_reg <= 1'b0;
                        state_reg      <= S_MTRY;
                    end
                    else
                    begin
                        out_reg       <= '{CMD_PLAY, dec_freq, dec_dur, CH_EFFECT};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_MTRY:
                begin
                    if (!cur_reg.player_busy && music_en_reg && mus_active_reg)
                    begin
                        if (catch_up_reg)
                        begin
                            catch_up_reg <= 1'b0;
                            ff_reg       <= {1'b0, cur_reg.now_ms - last_start_reg} + 33'd1;
                            f_reg        <= last_freq_reg;
                            d_reg        <= last_len_reg;
                            lap_reg      <= '0;
                            steps_reg    <= '0;
                            skipped_reg  <= 1'b0;
                            state_reg    <= S_FF_CHK;
                        end
                        else
                        begin
                            mus_pos_reg <= mus_pos_reg + 1'b1;
                            state_reg   <= S_MUS;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_MUS:
                begin
                    if (is_end)
                    begin
                        if (mus_loop_reg)
                        begin
                            mus_pos_reg <= mus_base_reg + 1'b1;
                        end
                        else
                        begin
                            mus_active_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        last_start_reg <= cur_reg.now_ms;
                        last_freq_reg  <= dec_freq;
                        last_len_reg   <= dec_dur;
                        out_reg        <= '{CMD_PLAY, dec_freq, dec_dur, CH_MUSIC};
                        out_valid_reg  <= 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_FF_CHK:
                begin
                    if (ff_reg >= {2'b00, d_reg})
                    begin
                        ff_reg      <= ff_reg - {2'b00, d_reg};
                        mus_pos_reg <= mus_pos_reg + 1'b1;
                        state_reg   <= S_FF_RD;
                    end
                    else
                    begin
                        last_start_reg <= cur_reg.now_ms;
                        last_freq_reg  <= f_reg;
                        last_len_reg   <= d_reg - ff_reg[30:0];
                        out_reg        <= '{CMD_PLAY, f_reg, d_reg - ff_reg[30:0], CH_MUSIC};
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                S_FF_RD:
                begin
                    if (is_end)
                    begin
                        if (mus_loop_reg)
                        begin
                            mus_pos_reg <= mus_base_reg + 1'b1;
                        end
                        else
                        begin
                            mus_active_reg <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        f_reg     <= dec_freq;
                        d_reg     <= dec_dur;
                        lap_reg   <= lap_sum;
                        steps_reg <= steps_reg + 1'b1;
                        if (!skipped_reg && (steps_reg + 1'b1) == STEP_W'(STORE_BYTES))
                        begin
                            skipped_reg <= 1'b1;
                            state_reg   <= S_FF_GO;
                        end
                        else
                        begin
                            state_reg <= S_FF_CHK;
                        end
                    end
                end
                S_FF_GO:
                begin
                    state_reg <= S_FF_MOD;
                end
                S_FF_MOD:
                begin
                    if (rem_done)
                    begin
                        ff_reg    <= rem_val;
                        state_reg <= S_FF_CHK;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/tcns_checker.sv
// tcns_checker.sv
// port-level checks of the note sequencer, bound to the top level
// depends on tcns_pkg and two_channel_note_sequencer_top_defines.svh
`include "two_channel_note_sequencer_top_defines.svh"
module tcns_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input tcns_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_ready,
    input tcns_pkg::result_t result
);
    import tcns_pkg::*;

    // a pending result holds until taken
`TCNS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
    // no new transaction while a result waits
`TCNS_ASSERT_IMP(a_ready_empty, item_ready, !result_valid)
    // silence carries no tone and comes from the effect channel
`TCNS_ASSERT_IMP(a_silence_clean, result_valid && result.tone_cmd == CMD_SILENCE, result.freq_hz == 13'd0 && result.duration_ms == 31'd0 && result.from_channel == CH_EFFECT)
    // a played tone always lasts at least one ms
`TCNS_ASSERT_IMP(a_play_len, result_valid && result.tone_cmd == CMD_PLAY, result.duration_ms != 31'd0)

endmodule

bind two_channel_note_sequencer_top tcns_checker u_tcns_checker (.*);
